// ===== rtl/core/sm4_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_pkg
// shared types, constants and round functions for the sm4 block cipher core
// ----------------------------------------------------------------------------
package sm4_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int RIDX_W      = $clog2(ROUND_COUNT);
  localparam int WORD_W      = 32;
  localparam int HALF_W      = 64;

  localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(ROUND_COUNT - 1);
  localparam logic [RIDX_W-1:0] ROUND_ONE  = RIDX_W'(1);

  typedef enum logic {
    OP_LOAD_KEY = 1'b0,
    OP_ENCRYPT  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [RIDX_W-1:0]  key_index;
    logic [WORD_W-1:0]  key_word;
    logic [HALF_W-1:0]  plain_high;
    logic [HALF_W-1:0]  plain_low;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [HALF_W-1:0]  cipher_high;
    logic [HALF_W-1:0]  cipher_low;
  } res_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [WORD_W-1:0] tau(input logic [WORD_W-1:0] x);
    tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [WORD_W-1:0] mix_linear(input logic [WORD_W-1:0] x);
    mix_linear = x ^ {x[29:0], x[31:30]} ^ {x[21:0], x[31:22]}
                   ^ {x[13:0], x[31:14]} ^ {x[7:0], x[31:8]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sm4_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4 channel interfaces
// valid/ready request channel and result channel of the sm4 core
// ----------------------------------------------------------------------------
interface sm4_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [4:0]  key_index;
  logic [31:0] key_word;
  logic [63:0] plain_high;
  logic [63:0] plain_low;

  modport source (
    output valid, operation, key_index, key_word, plain_high, plain_low,
    input  ready
  );
  modport sink (
    input  valid, operation, key_index, key_word, plain_high, plain_low,
    output ready
  );
endinterface

interface sm4_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;

  modport source (
    output valid, cipher_high, cipher_low,
    input  ready
  );
  modport sink (
    input  valid, cipher_high, cipher_low,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/core/sm4_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_core
// round key memory, round state and the shared round function
// ----------------------------------------------------------------------------
module sm4_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire sm4_pkg::req_t req,
  output sm4_pkg::res_t      res,
  input  wire logic          res_ready
);

  sm4_pkg::state_t state, state_next;

  logic [sm4_pkg::WORD_W-1:0] key_mem [sm4_pkg::ROUND_COUNT];
  logic [sm4_pkg::WORD_W-1:0] rkey;
  logic [sm4_pkg::RIDX_W-1:0] raddr;
  logic [sm4_pkg::RIDX_W-1:0] round;
  logic [sm4_pkg::WORD_W-1:0] w0, w1, w2, w3;
  logic [sm4_pkg::WORD_W-1:0] round_out;
  logic                       accept;
  logic                       start;

  assign accept = req_valid && req_ready;
  assign start  = accept && (req.operation == sm4_pkg::OP_ENCRYPT);

  // key memory: one write port for key loads, one registered read port
  always_ff @(posedge clk) begin
    if (accept && (req.operation == sm4_pkg::OP_LOAD_KEY)) begin
      key_mem[req.key_index] <= req.key_word;
    end
    rkey <= key_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sm4_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sm4_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sm4_pkg::ST_RUN;
        end
      end
      sm4_pkg::ST_RUN: begin
        if (round == sm4_pkg::LAST_ROUND) begin
          state_next = sm4_pkg::ST_DONE;
        end
      end
      sm4_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = sm4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sm4_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready       = 1'b0;
    res.valid       = 1'b0;
    res.cipher_high = {w3, w2};
    res.cipher_low  = {w1, w0};
    raddr           = '0;
    case (state)
      sm4_pkg::ST_IDLE: begin
        req_ready = 1'b1;
      end
      sm4_pkg::ST_RUN: begin
        raddr = round + sm4_pkg::ROUND_ONE;
      end
      sm4_pkg::ST_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign round_out = w0 ^ sm4_pkg::mix_linear(sm4_pkg::tau(w1 ^ w2 ^ w3 ^ rkey));

  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (state == sm4_pkg::ST_RUN) begin
      round <= round + sm4_pkg::ROUND_ONE;
    end else begin
      round <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w0 <= req.plain_high[63:32];
      w1 <= req.plain_high[31:0];
      w2 <= req.plain_low[63:32];
      w3 <= req.plain_low[31:0];
    end else if (state == sm4_pkg::ST_RUN) begin
      w0 <= w1;
      w1 <= w2;
      w2 <= w3;
      w3 <= round_out;
    end
  end

  a_start_run: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == sm4_pkg::ST_RUN) && (round == '0))
    else $error("encrypt request did not start round zero");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (req.operation == sm4_pkg::OP_LOAD_KEY) |=> state == sm4_pkg::ST_IDLE)
    else $error("key load left idle");

  a_round_step: assert property (@(posedge clk) disable iff (rst)
    (state == sm4_pkg::ST_RUN) && ($past(state) == sm4_pkg::ST_RUN)
      |-> round == $past(round) + sm4_pkg::ROUND_ONE)
    else $error("round counter skipped");

  a_last_done: assert property (@(posedge clk) disable iff (rst)
    (state == sm4_pkg::ST_RUN) && (round == sm4_pkg::LAST_ROUND)
      |=> state == sm4_pkg::ST_DONE)
    else $error("last round did not finish");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == sm4_pkg::ST_DONE) && !res_ready |=> $stable({w0, w1, w2, w3}))
    else $error("finished block changed while waiting");

endmodule
`default_nettype wire

// ===== rtl/core/sm4_block_encrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sm4_block_encrypt
// sm4 block encryption with a loadable 32-entry round key memory
// ----------------------------------------------------------------------------
// a key load request writes one round key; it gives no result. an encrypt
// request runs 32 rounds, one per round key read from the single read port
// of the key memory, and then hands the block over to the output register.
// one block is in flight at a time, so a new request is taken only once the
// finished block has left the core.
// the output register lets a new request start while a result waits.
// round keys must be loaded before use; unloaded entries read as garbage.
module sm4_block_encrypt (
  input  wire logic  clk,
  input  wire logic  rst,
  sm4_req_if.sink    req,
  sm4_rsp_if.source  rsp
);

  sm4_pkg::req_t core_req;
  sm4_pkg::res_t core_res;
  logic          core_req_ready;
  logic          rsp_free;
  logic          rsp_valid;
  logic [63:0]   cipher_high;
  logic [63:0]   cipher_low;

  assign core_req.operation  = sm4_pkg::op_t'(req.operation);
  assign core_req.key_index  = req.key_index;
  assign core_req.key_word   = req.key_word;
  assign core_req.plain_high = req.plain_high;
  assign core_req.plain_low  = req.plain_low;
  assign req.ready           = core_req_ready;

  sm4_core u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (core_req_ready),
    .req       (core_req),
    .res       (core_res),
    .res_ready (rsp_free)
  );

  assign rsp_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= core_res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_free && core_res.valid) begin
      cipher_high <= core_res.cipher_high;
      cipher_low  <= core_res.cipher_low;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.cipher_high = cipher_high;
  assign rsp.cipher_low  = cipher_low;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ready |=> rsp_valid && $stable({cipher_high, cipher_low}))
    else $error("result changed while stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    core_res.valid && rsp_valid && !rsp.ready |=> core_res.valid)
    else $error("finished block dropped while output full");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    core_res.valid && rsp_free |=> rsp_valid)
    else $error("finished block not registered");

endmodule
`default_nettype wire

// ===== tb/sv/tb_sm4_block_encrypt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sm4_block_encrypt
// Self-checking bench for the SM4 block encryption core. Requests go in on a
// valid/ready channel and ciphertext blocks come back on another. A
// scoreboard keeps its own copy of the 32 round keys and works out each
// expected ciphertext with its own 32-round SM4 datapath. A key load that is
// accepted updates the key copy. An encrypt request that is accepted queues
// the expected block, and every result is checked in order against that
// queue. All round keys are loaded before the first encryption. The sender
// and the receiver idle at random, the receiver once holds off long enough
// to back up the core, and the sender once pauses until the core drains.
// ----------------------------------------------------------------------------
package sm4_check_pkg;
  import sm4_pkg::*;

  localparam logic [7:0] SUB_BYTE [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  typedef struct packed {
    logic [HALF_W-1:0] high;
    logic [HALF_W-1:0] low;
  } cipher_t;

  class cipher_scoreboard;
    logic [WORD_W-1:0] key_store [ROUND_COUNT];
    cipher_t           pending_cipher [$];
    int                errors;

    function new();
      errors = 0;
      foreach (key_store[i]) key_store[i] = '0;
    endfunction

    function logic [WORD_W-1:0] rotate_left(logic [WORD_W-1:0] x, int n);
      return (x << n) | (x >> (WORD_W - n));
    endfunction

    function logic [WORD_W-1:0] substitute(logic [WORD_W-1:0] x);
      return {SUB_BYTE[x[31:24]], SUB_BYTE[x[23:16]], SUB_BYTE[x[15:8]], SUB_BYTE[x[7:0]]};
    endfunction

    function logic [WORD_W-1:0] diffuse(logic [WORD_W-1:0] x);
      return x ^ rotate_left(x, 2) ^ rotate_left(x, 10) ^ rotate_left(x, 18)
               ^ rotate_left(x, 24);
    endfunction

    function cipher_t sm4_encrypt(logic [HALF_W-1:0] plain_high, logic [HALF_W-1:0] plain_low);
      logic [WORD_W-1:0] w [4];
      logic [WORD_W-1:0] nxt;
      cipher_t           c;
      w[0] = plain_high[63:32];
      w[1] = plain_high[31:0];
      w[2] = plain_low[63:32];
      w[3] = plain_low[31:0];
      for (int r = 0; r < ROUND_COUNT; r++) begin
        nxt  = w[0] ^ diffuse(substitute(w[1] ^ w[2] ^ w[3] ^ key_store[r]));
        w[0] = w[1];
        w[1] = w[2];
        w[2] = w[3];
        w[3] = nxt;
      end
      c.high = {w[3], w[2]};
      c.low  = {w[1], w[0]};
      return c;
    endfunction

    function void note_request(op_t op, logic [RIDX_W-1:0] idx, logic [WORD_W-1:0] word,
                               logic [HALF_W-1:0] plain_high, logic [HALF_W-1:0] plain_low);
      if (op == OP_LOAD_KEY) begin
        key_store[idx] = word;
      end else begin
        pending_cipher.push_back(sm4_encrypt(plain_high, plain_low));
      end
    endfunction

    function void check_result(logic [HALF_W-1:0] cipher_high, logic [HALF_W-1:0] cipher_low);
      cipher_t exp_c;
      if (pending_cipher.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h %h", $time,
                 cipher_high, cipher_low);
        errors++;
        return;
      end
      exp_c = pending_cipher.pop_front();
      if (cipher_high !== exp_c.high) begin
        $display("%0t cipher_high mismatch: expected %h, actual %h", $time,
                 exp_c.high, cipher_high);
        errors++;
      end
      if (cipher_low !== exp_c.low) begin
        $display("%0t cipher_low mismatch: expected %h, actual %h", $time,
                 exp_c.low, cipher_low);
        errors++;
      end
    endfunction

    function void flush_missing();
      cipher_t exp_c;
      while (pending_cipher.size() > 0) begin
        exp_c = pending_cipher.pop_front();
        $display("%0t missing result: expected %h %h, actual none", $time,
                 exp_c.high, exp_c.low);
        errors++;
      end
    endfunction
  endclass
endpackage

module tb_sm4_block_encrypt;
  import sm4_pkg::*;
  import sm4_check_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  bit hold_request   = 1'b0;

  cipher_scoreboard sb = new();

  sm4_req_if req_ch ();
  sm4_rsp_if rsp_ch ();

  sm4_block_encrypt dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  initial begin
    #10_000_000;
    $display("tb_sm4_block_encrypt: errors");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(op_t'(req_ch.operation), req_ch.key_index, req_ch.key_word,
                        req_ch.plain_high, req_ch.plain_low);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_result(rsp_ch.cipher_high, rsp_ch.cipher_low);
      end
    end
  end

  // result side
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = receiver_quiet ? 0 : $urandom_range(0, 8);
        if (stall > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  task automatic send_request(input op_t op, input logic [RIDX_W-1:0] idx,
                              input logic [WORD_W-1:0] word,
                              input logic [HALF_W-1:0] plain_high,
                              input logic [HALF_W-1:0] plain_low);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= op;
    req_ch.key_index  <= idx;
    req_ch.key_word   <= word;
    req_ch.plain_high <= plain_high;
    req_ch.plain_low  <= plain_low;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    while (sb.pending_cipher.size() > 0) @(posedge clk);
  endtask

  function automatic logic [HALF_W-1:0] pick_half();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_random();
    if ($urandom_range(0, 3) == 0) begin
      send_request(OP_LOAD_KEY, RIDX_W'($urandom_range(0, ROUND_COUNT - 1)),
                   WORD_W'(pick_half()), pick_half(), pick_half());
    end else begin
      send_request(OP_ENCRYPT, RIDX_W'($urandom), WORD_W'($urandom), pick_half(),
                   pick_half());
    end
  endtask

  initial begin
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_LOAD_KEY;
    req_ch.key_index  <= '0;
    req_ch.key_word   <= '0;
    req_ch.plain_high <= '0;
    req_ch.plain_low  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every round key is written before the first encryption
    for (int i = 0; i < ROUND_COUNT; i++) begin
      case (i)
        0:                send_request(OP_LOAD_KEY, RIDX_W'(i), '0, '1, '1);
        1:                send_request(OP_LOAD_KEY, RIDX_W'(i), 32'h8000_0000, '0, '0);
        2:                send_request(OP_LOAD_KEY, RIDX_W'(i), 32'h0000_0001, '0, '0);
        ROUND_COUNT - 1:  send_request(OP_LOAD_KEY, RIDX_W'(i), '1, '0, '0);
        default:          send_request(OP_LOAD_KEY, RIDX_W'(i), $urandom, '0, '0);
      endcase
    end
    send_request(OP_ENCRYPT, '0, '0, '0, '0);
    send_request(OP_ENCRYPT, '1, '1, '1, '1);
    sender_quiet = 1'b1;
    send_request(OP_ENCRYPT, 5'h15, 32'h5a5a_5a5a, 64'h0123_4567_89ab_cdef,
                 64'hfedc_ba98_7654_3210);
    send_request(OP_ENCRYPT, '0, '0, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_request(OP_LOAD_KEY, '0, '1, '0, '0);
    send_request(OP_LOAD_KEY, '1, '0, '0, '0);
    send_request(OP_ENCRYPT, '0, '0, '0, '0);
    sender_quiet = 1'b0;
    send_request(OP_ENCRYPT, '0, '0, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);

    for (int phase = 0; phase < 8; phase++) begin
      sender_quiet   = (phase == 1) || (phase == 5);
      receiver_quiet = (phase == 3) || (phase == 5);
      if (phase == 2) begin
        hold_request = 1'b1;
        sender_quiet = 1'b1;
        repeat (40) send_request(OP_ENCRYPT, RIDX_W'($urandom), WORD_W'($urandom),
                                 pick_half(), pick_half());
        sender_quiet = 1'b0;
      end
      if (phase == 6) begin
        wait_for_results();
        repeat (20) @(posedge clk);
      end
      repeat (250) send_random();
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.flush_missing();
    if (sb.errors == 0) begin
      $display("tb_sm4_block_encrypt: clean");
    end else begin
      $display("tb_sm4_block_encrypt: errors");
    end
    $finish;
  end
endmodule
